// ----- sv/affine_transform_engine_assert.svh -----
// Assertion macros for the RTL that checks itself in simulation.
`ifndef AFFINE_TRANSFORM_ENGINE_ASSERT_SVH
`define AFFINE_TRANSFORM_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define ATE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ate assertion failed");
`define ATE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ate assertion failed");
`else
`define ATE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ATE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/ate_pkg.sv -----
package ate_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int MAT_N     = 4;

    typedef logic signed [DATA_W-1:0] t_fx;
    typedef logic signed [PROD_W-1:0] t_wide;
    typedef t_fx t_matrix [MAT_N][MAT_N];

    typedef enum logic [1:0] {
        OP_IDENTITY  = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_SCALE     = 2'd2,
        OP_POINT     = 2'd3
    } t_opcode;

    localparam t_fx   FX_ONE  = t_fx'(1) <<< FRAC_BITS;
    localparam t_fx   FX_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_fx   FX_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_wide SUM_MAX = PROD_W'(FX_MAX);
    localparam t_wide SUM_MIN = PROD_W'(FX_MIN);

    // The arithmetic shift rounds the product toward minus infinity.
    function automatic t_wide fx_mul(input t_fx a, input t_fx b);
        t_wide ae;
        t_wide be;
        t_wide p;
        ae = PROD_W'(a);
        be = PROD_W'(b);
        p  = ae * be;
        return p >>> FRAC_BITS;
    endfunction

    function automatic t_fx sat_fx(input t_wide v);
        t_fx r;
        if (v > SUM_MAX) begin
            r = FX_MAX;
        end else if (v < SUM_MIN) begin
            r = FX_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic t_matrix identity_matrix();
        t_matrix m;
        for (int i = 0; i < MAT_N; i++) begin
            for (int j = 0; j < MAT_N; j++) begin
                m[i][j] = (i == j) ? FX_ONE : '0;
            end
        end
        return m;
    endfunction

endpackage

// ----- sv/ate_datapath.sv -----
module ate_datapath
    import ate_pkg::*;
(
    input  t_opcode i_opcode,
    input  t_fx     i_x_value,
    input  t_fx     i_y_value,
    input  t_fx     i_z_value,
    input  t_matrix i_matrix,
    output t_matrix o_matrix,
    output t_fx     o_point_x,
    output t_fx     o_point_y,
    output t_fx     o_point_z
);

    t_fx   operand [3];
    t_wide prod [3][MAT_N];
    t_wide col_sum [MAT_N];

    assign operand[0] = i_x_value;
    assign operand[1] = i_y_value;
    assign operand[2] = i_z_value;

    // The twelve products serve translate, scale and point transforms alike.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < MAT_N; j++) begin
                prod[i][j] = fx_mul(operand[i], i_matrix[i][j]);
            end
        end
        for (int j = 0; j < MAT_N; j++) begin
            col_sum[j] = PROD_W'(i_matrix[3][j]) + prod[0][j] + prod[1][j] + prod[2][j];
        end
    end

    always_comb begin
        o_matrix = i_matrix;
        unique case (i_opcode)
            OP_IDENTITY: begin
                o_matrix = identity_matrix();
            end
            OP_TRANSLATE: begin
                for (int j = 0; j < MAT_N; j++) begin
                    o_matrix[3][j] = sat_fx(col_sum[j]);
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < MAT_N; j++) begin
                        o_matrix[i][j] = sat_fx(prod[i][j]);
                    end
                end
            end
            OP_POINT: begin
                o_matrix = i_matrix;
            end
            default: begin
                o_matrix = i_matrix;
            end
        endcase
    end

    assign o_point_x = sat_fx(col_sum[0]);
    assign o_point_y = sat_fx(col_sum[1]);
    assign o_point_z = sat_fx(col_sum[2]);

endmodule

// ----- sv/affine_transform_engine.sv -----
// Fixed-point 4x4 vertex transform engine.
// The input channel (i_in_valid, o_in_ready) carries an opcode and three
// signed fixed-point operands: load identity, compose a translation, compose a
// scale, or transform a point by the current matrix.
// Only a point transform produces an item on the output channel
// (o_out_valid, i_out_ready), carrying the transformed x, y and z.
// Every item is registered at the input and its work is done from that
// register; a point result is registered again before it is presented.
// One item is accepted every cycle unless a point item waits; the matrix is
// updated in the cycle after acceptance, so the following item already sees it.
// When the receiver stalls with a result waiting, a point item held in the
// input register waits and the input ready drops; a held matrix item still advances.
// Synchronous reset clears both valid flags and loads the identity matrix.
module affine_transform_engine
    import ate_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_opcode,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_value,
    input  logic signed [DATA_W-1:0] i_z_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_point_x,
    output logic signed [DATA_W-1:0] o_point_y,
    output logic signed [DATA_W-1:0] o_point_z
);

`include "affine_transform_engine_assert.svh"

    logic    r_in_valid;
    t_opcode r_in_op;
    t_fx     r_in_x;
    t_fx     r_in_y;
    t_fx     r_in_z;
    t_matrix r_mat;
    logic    r_out_valid;
    t_fx     r_out_x;
    t_fx     r_out_y;
    t_fx     r_out_z;

    t_matrix n_mat;
    t_fx     n_point_x;
    t_fx     n_point_y;
    t_fx     n_point_z;
    logic    out_free;
    logic    advance;

    ate_datapath u_datapath (
        .i_opcode  (r_in_op),
        .i_x_value (r_in_x),
        .i_y_value (r_in_y),
        .i_z_value (r_in_z),
        .i_matrix  (r_mat),
        .o_matrix  (n_mat),
        .o_point_x (n_point_x),
        .o_point_y (n_point_y),
        .o_point_z (n_point_z)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && ((r_in_op != OP_POINT) || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mat       <= identity_matrix();
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && (r_in_op != OP_POINT)) begin
                r_mat <= n_mat;
            end
            if (advance && (r_in_op == OP_POINT)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op <= t_opcode'(i_opcode);
            r_in_x  <= i_x_value;
            r_in_y  <= i_y_value;
            r_in_z  <= i_z_value;
        end
        if (advance && (r_in_op == OP_POINT)) begin
            r_out_x <= n_point_x;
            r_out_y <= n_point_y;
            r_out_z <= n_point_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r_out_z;

    `ATE_ASSERT_NXT(a_no_spurious_result, i_clk, i_rst_n, (!r_in_valid || r_in_op != OP_POINT) && i_out_ready, !o_out_valid)
    `ATE_ASSERT_NXT(a_point_waits, i_clk, i_rst_n, r_in_valid && r_in_op == OP_POINT && r_out_valid && !i_out_ready, r_in_valid && r_in_op == OP_POINT)
    `ATE_ASSERT_NXT(a_identity_load, i_clk, i_rst_n, r_in_valid && r_in_op == OP_IDENTITY, r_mat[3][0] == '0 && r_mat[1][1] == FX_ONE)
    `ATE_ASSERT_IMP(a_reset_identity, i_clk, i_rst_n, $rose(i_rst_n), r_mat[0][0] == FX_ONE && r_mat[3][2] == '0 && !o_out_valid)

endmodule

// ----- sim/affine_transform_engine_tb.sv -----
module affine_transform_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ate_pkg::*;

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned ITEM_TARGET  = 950;

    typedef struct packed {
        t_opcode op;
        t_fx     x;
        t_fx     y;
        t_fx     z;
    } t_vertex_cmd;

    typedef struct packed {
        t_fx x;
        t_fx y;
        t_fx z;
    } t_point;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_fx         point_x;
    t_fx         point_y;
    t_fx         point_z;
    t_vertex_cmd drive_cmd = '0;

    t_vertex_cmd pending_cmds [$];
    t_point      expected_points [$];
    t_fx         cur_matrix [MAT_N][MAT_N];
    int unsigned cmds_left = 0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned rx_phase_left = 0;
    t_rx_mode    rx_mode = RX_ALWAYS;
    logic [7:0]  rx_mask = 8'hff;
    t_point      got_point;
    t_point      want_point;

    affine_transform_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_opcode    (drive_cmd.op),
        .i_x_value   (drive_cmd.x),
        .i_y_value   (drive_cmd.y),
        .i_z_value   (drive_cmd.z),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_point_x   (point_x),
        .o_point_y   (point_y),
        .o_point_z   (point_z)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Product rounded toward minus infinity by the arithmetic shift.
    function automatic longint fx_product(input t_fx a, input t_fx b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> FRAC_BITS;
    endfunction

    function automatic t_fx clamp_fx(input longint v);
        t_fx r;
        if (v > longint'(FX_MAX)) begin
            r = FX_MAX;
        end else if (v < longint'(FX_MIN)) begin
            r = FX_MIN;
        end else begin
            r = t_fx'(v);
        end
        return r;
    endfunction

    task automatic load_unit_matrix();
        for (int i = 0; i < MAT_N; i++) begin
            for (int j = 0; j < MAT_N; j++) begin
                cur_matrix[i][j] = (i == j) ? (t_fx'(1) <<< FRAC_BITS) : t_fx'(0);
            end
        end
    endtask

    task automatic apply_vertex_op(input t_vertex_cmd cmd);
        t_fx    operand [3];
        t_fx    new_row [MAT_N];
        longint acc;
        t_point pt;
        operand[0] = cmd.x;
        operand[1] = cmd.y;
        operand[2] = cmd.z;
        case (cmd.op)
            OP_IDENTITY: begin
                load_unit_matrix();
            end
            OP_TRANSLATE: begin
                for (int j = 0; j < MAT_N; j++) begin
                    acc = longint'(cur_matrix[3][j]);
                    for (int i = 0; i < 3; i++) begin
                        acc += fx_product(operand[i], cur_matrix[i][j]);
                    end
                    new_row[j] = clamp_fx(acc);
                end
                for (int j = 0; j < MAT_N; j++) begin
                    cur_matrix[3][j] = new_row[j];
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < MAT_N; j++) begin
                        cur_matrix[i][j] = clamp_fx(fx_product(operand[i], cur_matrix[i][j]));
                    end
                end
            end
            default: begin
                for (int j = 0; j < 3; j++) begin
                    acc = longint'(cur_matrix[3][j]);
                    for (int i = 0; i < 3; i++) begin
                        acc += fx_product(cur_matrix[i][j], operand[i]);
                    end
                    new_row[j] = clamp_fx(acc);
                end
                pt.x = new_row[0];
                pt.y = new_row[1];
                pt.z = new_row[2];
                expected_points.push_back(pt);
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_cmd(input t_opcode op, input t_fx x, input t_fx y, input t_fx z);
        t_vertex_cmd cmd;
        cmd.op = op;
        cmd.x  = x;
        cmd.y  = y;
        cmd.z  = z;
        pending_cmds.push_back(cmd);
    endtask

    // Signed value spread over the given number of bits.
    function automatic t_fx rand_fx(input int bits);
        t_fx v;
        v = $signed($urandom);
        return v >>> (DATA_W - bits);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                apply_vertex_op(drive_cmd);
                cmds_left--;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    drive_cmd <= pending_cmds.pop_front();
                    in_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       <= t_rx_mode'($urandom_range(0, 2));
                rx_mask       <= 8'($urandom_range(1, 255));
                rx_phase_left <= $urandom_range(20, 200);
            end else begin
                rx_phase_left <= rx_phase_left - 1;
                rx_mask       <= {rx_mask[0], rx_mask[7:1]};
            end
            case (rx_mode)
                RX_ALWAYS: begin
                    out_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    out_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    out_ready <= rx_mask[0];
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                got_point.x = point_x;
                got_point.y = point_y;
                got_point.z = point_z;
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected result (%0d, %0d, %0d)",
                        got_point.x, got_point.y, got_point.z));
                end else begin
                    want_point = expected_points.pop_front();
                    if (got_point.x !== want_point.x) begin
                        report_mismatch($sformatf("point_x got %0d expected %0d",
                            got_point.x, want_point.x));
                    end
                    if (got_point.y !== want_point.y) begin
                        report_mismatch($sformatf("point_y got %0d expected %0d",
                            got_point.y, want_point.y));
                    end
                    if (got_point.z !== want_point.z) begin
                        report_mismatch($sformatf("point_z got %0d expected %0d",
                            got_point.z, want_point.z));
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int n_ops;
        int n_pts;
        load_unit_matrix();

        push_cmd(OP_POINT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        push_cmd(OP_POINT, FX_MAX, FX_MIN, 32'sh0000_0000);
        push_cmd(OP_IDENTITY, FX_MIN, FX_MAX, 32'shffff_ffff);
        push_cmd(OP_TRANSLATE, FX_MAX, FX_MAX, FX_MAX);
        push_cmd(OP_TRANSLATE, FX_MAX, FX_MAX, FX_MAX);
        push_cmd(OP_POINT, FX_MAX, FX_MAX, FX_MAX);
        push_cmd(OP_TRANSLATE, FX_MIN, FX_MIN, FX_MIN);
        push_cmd(OP_TRANSLATE, FX_MIN, FX_MIN, FX_MIN);
        push_cmd(OP_POINT, FX_MIN, FX_MIN, FX_MIN);
        push_cmd(OP_IDENTITY, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        push_cmd(OP_SCALE, 32'sh0000_8000, 32'shffff_8000, FX_MAX);
        push_cmd(OP_POINT, 32'shffff_ffff, 32'sh0000_0001, 32'shffff_ffff);
        push_cmd(OP_SCALE, FX_MAX, FX_MIN, FX_MAX);
        push_cmd(OP_POINT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        push_cmd(OP_SCALE, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        push_cmd(OP_POINT, FX_MAX, FX_MIN, FX_MAX);
        push_cmd(OP_IDENTITY, 32'sh1234_5678, 32'shffff_0000, 32'sh7fff_0000);
        push_cmd(OP_TRANSLATE, 32'sh0001_8000, 32'shfffd_c000, 32'sh0003_0000);
        push_cmd(OP_SCALE, 32'sh0002_0000, 32'sh0003_0000, 32'shffff_0000);
        push_cmd(OP_TRANSLATE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        push_cmd(OP_POINT, 32'sh0000_8000, 32'shffff_4000, 32'sh000a_0000);
        push_cmd(OP_POINT, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);

        // Mostly whole transform set-ups followed by vertex runs, with raw noise mixed in.
        while (pending_cmds.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 1) == 1) begin
                    push_cmd(OP_IDENTITY, t_fx'($urandom), t_fx'($urandom), t_fx'($urandom));
                end
                n_ops = $urandom_range(0, 3);
                repeat (n_ops) begin
                    if ($urandom_range(0, 1) == 1) begin
                        push_cmd(OP_TRANSLATE, rand_fx(27), rand_fx(27), rand_fx(27));
                    end else begin
                        push_cmd(OP_SCALE, rand_fx(19), rand_fx(19), rand_fx(19));
                    end
                end
                n_pts = $urandom_range(2, 8);
                repeat (n_pts) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_cmd(OP_POINT, rand_fx(32), rand_fx(32), rand_fx(32));
                    end else begin
                        push_cmd(OP_POINT, rand_fx(29), rand_fx(29), rand_fx(29));
                    end
                end
            end else begin
                push_cmd(t_opcode'($urandom_range(0, 3)),
                    t_fx'($urandom), t_fx'($urandom), t_fx'($urandom));
            end
        end
        cmds_left = pending_cmds.size();

        while (cmds_left != 0 || expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
